@@ rtl/core/vcl_pkg.sv @@
// Shared constants, register codes and types for the velocity command limiter.
// Used by velocity_command_limiter_unit and vcl_div_lane; depends on nothing else.
package vcl_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int FIELD_W     = 16;
	localparam int LIMIT_W     = 15;
	localparam int MAG_W       = FIELD_W + 1;
	localparam int SUM_W       = 2 * FIELD_W;
	localparam int ROOT_W      = FIELD_W;
	localparam int SQ_REM_W    = ROOT_W + 3;
	localparam int RATIO_W     = FRAC_BITS + 1;
	localparam int RATIO_STEPS = RATIO_W;
	localparam int FRONT_STAGES = (RATIO_STEPS > ROOT_W) ? RATIO_STEPS : ROOT_W;
	localparam int PROD_W      = MAG_W + LIMIT_W;
	localparam int QUO_W       = FIELD_W;
	localparam int FPROD_W     = MAG_W + RATIO_W;
	localparam int CFG_IDX_W   = 1;

	localparam logic [LIMIT_W-1:0] LIN_LIMIT_RESET = LIMIT_W'(1638);
	localparam logic [LIMIT_W-1:0] YAW_LIMIT_RESET = LIMIT_W'(2048);
	localparam logic [RATIO_W-1:0] RATIO_HALF       = RATIO_W'(1 << (FRAC_BITS - 1));
	localparam logic [RATIO_W-1:0] RATIO_THREE_HALF = RATIO_W'(3 << (FRAC_BITS - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIN_LIMIT = 1'b0,
		REG_YAW_LIMIT = 1'b1
	} cfg_reg_t;

	// Per-item data that rides alongside the arithmetic.
	typedef struct packed {
		logic               sx;
		logic               sy;
		logic [MAG_W-1:0]   ax;
		logic [MAG_W-1:0]   ay;
		logic [FIELD_W-1:0] w_out;
	} side_t;

endpackage

@@ rtl/core/vcl_div_lane.sv @@
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on vcl_pkg for widths.
module vcl_div_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [vcl_pkg::PROD_W-1:0]  dividend,
	input  logic [vcl_pkg::ROOT_W-1:0]  divisor,
	output logic [vcl_pkg::QUO_W-1:0]   quotient
);

	localparam int N  = vcl_pkg::QUO_W;
	localparam int DW = vcl_pkg::ROOT_W;

	// The quotient is known to fit N bits whenever it is used, so the
	// partial remainder starts from the dividend bits above the low N.
	logic [DW-1:0] rem_s [0:N-1];
	logic [N-1:0]  low_s [0:N-1];
	logic [DW-1:0] div_s [0:N-1];
	logic [N-1:0]  q_s   [0:N-1];

	genvar j;
	generate
		for (j = 0; j < N; j++) begin : g_step
			logic [DW-1:0] p_rem;
			logic [N-1:0]  p_low;
			logic [DW-1:0] p_div;
			logic [N-1:0]  p_q;
			logic [DW:0]   r;
			logic          ge;
			if (j == 0) begin : g_first
				assign p_rem = DW'(dividend >> N);
				assign p_low = dividend[N-1:0];
				assign p_div = divisor;
				assign p_q   = '0;
			end else begin : g_rest
				assign p_rem = rem_s[j-1];
				assign p_low = low_s[j-1];
				assign p_div = div_s[j-1];
				assign p_q   = q_s[j-1];
			end
			assign r  = {p_rem, p_low[N-1]};
			assign ge = (r >= {1'b0, p_div});
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? DW'(r - {1'b0, p_div}) : DW'(r);
					low_s[j] <= p_low << 1;
					div_s[j] <= p_div;
					q_s[j]   <= {p_q[N-2:0], ge};
				end
			end
		end
	endgenerate

	assign quotient = q_s[N-1];

endmodule

@@ rtl/core/velocity_command_limiter_unit.sv @@
// Top level of the planar velocity command limiter: a fully pipelined datapath.
// Depends on vcl_pkg and instantiates two vcl_div_lane dividers.
//
// The block takes one velocity command transaction (forward, lateral, yaw rate, all
// signed Q4.12) per clock while the output is not stalled and returns one limited
// command per transaction, in order. The planar speed floor(sqrt(x^2+y^2)) is found
// by a 16-stage digit-by-digit square root; in the same stages a 13-stage divider
// forms the yaw ratio |yaw|/yaw limit. If the speed exceeds the linear limit, both
// linear components are scaled by limit/speed through two 16-stage divider lanes.
// The yaw rate is clamped to the yaw limit with its sign kept, and when the ratio is
// above one half the linear parts are further scaled by 1.5 minus the ratio. All
// scaling truncates toward zero. A new transaction can be accepted every cycle
// unless the output is stalled, which freezes the whole pipeline; in_stall follows
// out_stall while a result is waiting. Registers are written through the configuration
// channel (always ready) and must only be changed while no transaction is in flight;
// the limits are read directly by the input, ratio, middle and coupling stages.
module velocity_command_limiter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [vcl_pkg::FIELD_W-1:0]    forward_speed,
	input  logic signed [vcl_pkg::FIELD_W-1:0]    lateral_speed,
	input  logic signed [vcl_pkg::FIELD_W-1:0]    yaw_rate,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [vcl_pkg::FIELD_W-1:0]    forward_limited,
	output logic signed [vcl_pkg::FIELD_W-1:0]    lateral_limited,
	output logic signed [vcl_pkg::FIELD_W-1:0]    yaw_limited,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vcl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vcl_pkg::LIMIT_W-1:0]           cfg_data
);

	localparam int FW = vcl_pkg::FIELD_W;
	localparam int MW = vcl_pkg::MAG_W;
	localparam int LW = vcl_pkg::LIMIT_W;
	localparam int SW = vcl_pkg::SUM_W;
	localparam int RW = vcl_pkg::ROOT_W;
	localparam int QW = vcl_pkg::SQ_REM_W;
	localparam int TW = vcl_pkg::RATIO_W;
	localparam int FS = vcl_pkg::FRONT_STAGES;
	localparam int PW = vcl_pkg::PROD_W;
	localparam int DN = vcl_pkg::QUO_W;
	localparam int XW = vcl_pkg::FPROD_W;

	// Configuration registers.
	logic [LW-1:0] lin_lim_q;
	logic [LW-1:0] yaw_lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_lim_q <= vcl_pkg::LIN_LIMIT_RESET;
			yaw_lim_q <= vcl_pkg::YAW_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vcl_pkg::cfg_reg_t'(cfg_index))
				vcl_pkg::REG_LIN_LIMIT: lin_lim_q <= cfg_data;
				vcl_pkg::REG_YAW_LIMIT: yaw_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together unless a finished result is held.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Input stage: magnitudes, yaw clamp and the sum of squares.
	logic [MW-1:0] ax_c, ay_c, aw_c;
	logic [LW-1:0] aw_lim;
	logic [FW-1:0] w_c;
	logic [SW-1:0] sqx, sqy;

	always_comb begin
		ax_c = forward_speed[FW-1] ? MW'(~{forward_speed[FW-1], forward_speed}) + MW'(1)
			: {1'b0, forward_speed};
		ay_c = lateral_speed[FW-1] ? MW'(~{lateral_speed[FW-1], lateral_speed}) + MW'(1)
			: {1'b0, lateral_speed};
		aw_c = yaw_rate[FW-1] ? MW'(~{yaw_rate[FW-1], yaw_rate}) + MW'(1)
			: {1'b0, yaw_rate};
		if (aw_c > MW'(yaw_lim_q)) begin
			aw_lim = yaw_lim_q;
			w_c    = yaw_rate[FW-1] ? FW'(0) - FW'(yaw_lim_q) : FW'(yaw_lim_q);
		end else begin
			aw_lim = LW'(aw_c);
			w_c    = yaw_rate;
		end
		sqx = SW'(ax_c);
		sqy = SW'(ay_c);
	end

	// Front section: square root and yaw ratio division, one digit per stage.
	logic                  f_v_s    [0:FS];
	vcl_pkg::side_t        f_side_s [0:FS];
	logic [SW-1:0]         f_n_s    [0:FS];
	logic [QW-1:0]         f_rem_s  [0:FS];
	logic [RW-1:0]         f_root_s [0:FS];
	logic [LW-1:0]         f_rrem_s [0:FS];
	logic [TW-1:0]         f_ratio_s[0:FS];
	logic                  rb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_s[0] <= 1'b0;
		end else if (adv) begin
			f_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_side_s[0]  <= '{sx: forward_speed[FW-1], sy: lateral_speed[FW-1],
				ax: ax_c, ay: ay_c, w_out: w_c};
			f_n_s[0]     <= sqx * sqx + sqy * sqy;
			f_rem_s[0]   <= '0;
			f_root_s[0]  <= '0;
			f_rrem_s[0]  <= aw_lim >> 1;
			f_ratio_s[0] <= '0;
			rb_s1        <= aw_lim[0];
		end
	end

	genvar k;
	generate
		for (k = 0; k < FS; k++) begin : g_front
			logic [SW-1:0] n_n;
			logic [QW-1:0] rem_n;
			logic [RW-1:0] root_n;
			logic [LW-1:0] rrem_n;
			logic [TW-1:0] ratio_n;

			if (k < RW) begin : g_sqrt
				logic [QW-1:0] r;
				logic [QW-1:0] t;
				logic          ge;
				assign r      = {f_rem_s[k][QW-3:0], f_n_s[k][SW-1 -: 2]};
				assign t      = QW'({f_root_s[k], 2'b01});
				assign ge     = (r >= t);
				assign rem_n  = ge ? r - t : r;
				assign root_n = {f_root_s[k][RW-2:0], ge};
				assign n_n    = f_n_s[k] << 2;
			end else begin : g_sqrt_pass
				assign rem_n  = f_rem_s[k];
				assign root_n = f_root_s[k];
				assign n_n    = f_n_s[k];
			end

			if (k < vcl_pkg::RATIO_STEPS) begin : g_ratio
				logic [LW:0] rr;
				logic        ge2;
				logic        nb;
				if (k == 0) begin : g_b0
					assign nb = rb_s1;
				end else begin : g_bz
					assign nb = 1'b0;
				end
				assign rr      = {f_rrem_s[k], nb};
				assign ge2     = (rr >= {1'b0, yaw_lim_q});
				assign rrem_n  = ge2 ? LW'(rr - {1'b0, yaw_lim_q}) : LW'(rr);
				assign ratio_n = {f_ratio_s[k][TW-2:0], ge2};
			end else begin : g_ratio_pass
				assign rrem_n  = f_rrem_s[k];
				assign ratio_n = f_ratio_s[k];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					f_v_s[k+1] <= 1'b0;
				end else if (adv) begin
					f_v_s[k+1] <= f_v_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					f_side_s[k+1]  <= f_side_s[k];
					f_n_s[k+1]     <= n_n;
					f_rem_s[k+1]   <= rem_n;
					f_root_s[k+1]  <= root_n;
					f_rrem_s[k+1]  <= rrem_n;
					f_ratio_s[k+1] <= ratio_n;
				end
			end
		end
	endgenerate

	// Middle stage: limit products and the over-limit decision.
	logic           m_v_s;
	vcl_pkg::side_t m_side_s;
	logic [PW-1:0]  m_px_s, m_py_s;
	logic [RW-1:0]  m_spd_s;
	logic           m_scl_s;
	logic [TW-1:0]  m_ratio_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_s <= 1'b0;
		end else if (adv) begin
			m_v_s <= f_v_s[FS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_side_s  <= f_side_s[FS];
			m_px_s    <= PW'(f_side_s[FS].ax) * PW'(lin_lim_q);
			m_py_s    <= PW'(f_side_s[FS].ay) * PW'(lin_lim_q);
			m_spd_s   <= f_root_s[FS];
			m_scl_s   <= (f_root_s[FS] > RW'(lin_lim_q));
			m_ratio_s <= f_ratio_s[FS];
		end
	end

	// Divider section: two lanes with the side data delayed to match.
	logic [DN-1:0] qx, qy;

	vcl_div_lane u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (m_px_s),
		.divisor  (m_spd_s),
		.quotient (qx)
	);

	vcl_div_lane u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (m_py_s),
		.divisor  (m_spd_s),
		.quotient (qy)
	);

	logic           d_v_s     [0:DN-1];
	vcl_pkg::side_t d_side_s  [0:DN-1];
	logic           d_scl_s   [0:DN-1];
	logic [TW-1:0]  d_ratio_s [0:DN-1];

	genvar j;
	generate
		for (j = 0; j < DN; j++) begin : g_delay
			logic           pv;
			vcl_pkg::side_t pside;
			logic           pscl;
			logic [TW-1:0]  pratio;
			if (j == 0) begin : g_first
				assign pv     = m_v_s;
				assign pside  = m_side_s;
				assign pscl   = m_scl_s;
				assign pratio = m_ratio_s;
			end else begin : g_rest
				assign pv     = d_v_s[j-1];
				assign pside  = d_side_s[j-1];
				assign pscl   = d_scl_s[j-1];
				assign pratio = d_ratio_s[j-1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					d_v_s[j] <= 1'b0;
				end else if (adv) begin
					d_v_s[j] <= pv;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					d_side_s[j]  <= pside;
					d_scl_s[j]   <= pscl;
					d_ratio_s[j] <= pratio;
				end
			end
		end
	endgenerate

	// Coupling stage: scale by 1.5 minus the ratio when the yaw is above half its limit.
	vcl_pkg::side_t dl;
	logic [MW-1:0]  mag_x, mag_y;
	logic           cpl;
	logic [TW-1:0]  factor;

	assign dl     = d_side_s[DN-1];
	assign mag_x  = d_scl_s[DN-1] ? MW'(qx) : dl.ax;
	assign mag_y  = d_scl_s[DN-1] ? MW'(qy) : dl.ay;
	assign cpl    = (yaw_lim_q != '0) && (d_ratio_s[DN-1] > vcl_pkg::RATIO_HALF);
	assign factor = vcl_pkg::RATIO_THREE_HALF - d_ratio_s[DN-1];

	logic          c_v_s;
	logic [XW-1:0] c_px_s, c_py_s;
	logic          c_sx_s, c_sy_s;
	logic [FW-1:0] c_w_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_v_s <= 1'b0;
		end else if (adv) begin
			c_v_s <= d_v_s[DN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_px_s <= cpl ? XW'(mag_x) * XW'(factor) : XW'(mag_x) << vcl_pkg::FRAC_BITS;
			c_py_s <= cpl ? XW'(mag_y) * XW'(factor) : XW'(mag_y) << vcl_pkg::FRAC_BITS;
			c_sx_s <= dl.sx;
			c_sy_s <= dl.sy;
			c_w_s  <= dl.w_out;
		end
	end

	// Output register: drop the fraction and restore the signs.
	logic [MW-1:0] res_x, res_y;
	logic          out_valid_q;
	logic [FW-1:0] fwd_q, lat_q, yaw_q;

	assign res_x = MW'(c_px_s >> vcl_pkg::FRAC_BITS);
	assign res_y = MW'(c_py_s >> vcl_pkg::FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= c_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_q <= c_sx_s ? FW'(MW'(0) - res_x) : FW'(res_x);
			lat_q <= c_sy_s ? FW'(MW'(0) - res_y) : FW'(res_y);
			yaw_q <= c_w_s;
		end
	end

	assign out_valid       = out_valid_q;
	assign forward_limited = fwd_q;
	assign lateral_limited = lat_q;
	assign yaw_limited     = yaw_q;

	// Checks on the datapath.
	logic [MW-1:0] yaw_out_abs;
	assign yaw_out_abs = yaw_q[FW-1] ? MW'(~{yaw_q[FW-1], yaw_q}) + MW'(1) : {1'b0, yaw_q};

	a_yaw_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_out_abs <= MW'(yaw_lim_q)))
		else $error("yaw output exceeds its limit");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (c_v_s == $past(c_v_s)) && (m_v_s == $past(m_v_s)))
		else $error("pipeline moved while the output was held");

	a_speed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_v_s && m_scl_s) |-> (m_spd_s != '0))
		else $error("linear scaling selected with a zero speed");

endmodule
